### design/rv32ie_pkg.sv
// Package for the RV32I instruction executor: opcodes, function codes and status codes.
// Used by rv32i_instruction_executor_core; has no dependencies of its own.
`default_nettype none

package rv32ie_pkg;

   // major opcodes
   localparam logic [6:0] OP_MASK   = 7'h7F;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_LOAD   = 7'h03;

   localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

   // funct7 values
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // ALU funct3
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // load and store funct3
   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   // branch funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_HALT    = 2'd1,
      ST_ILLEGAL = 2'd2
   } status_type;

endpackage

`default_nettype wire

### design/rv32i_instruction_executor_core.sv
// Top level of the RV32I instruction executor: decode, execute, load/store and write-back.
// Depends on rv32ie_pkg and rv32ie_ram. MEM_BYTES is taken as a power of two.
//
//   channel | direction | ports                                    | request
//   req     | in        | req_valid, req_stall, req_instr_word     | one instruction
//   rsp     | out       | rsp_valid, rsp_stall, rsp_next_pc, ...   | one result
//
// An instruction passes through a register read stage, then execute; loads add a stage for
// the synchronous data memory read. The rate is one request a cycle while rsp_stall is low,
// but a load holds off the next request until it has moved on to the memory read stage.
// After reset the data memory is swept to zero, with req_stall high.
// A stalled result holds in the output register; execution of non-loads waits behind it.
`default_nettype none

module rv32i_instruction_executor_core
   import rv32ie_pkg::*;
#(
   parameter int MEM_BYTES = 4096,
   parameter int REG_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic [1:0]       rsp_exec_status
);

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int ROWS   = MEM_BYTES / 4;
   localparam int ROW_W  = ADDR_W - 2;
   localparam int RF_AW  = $clog2(REG_COUNT);

   // control registers
   logic              clearing_ff, clearing_in;
   logic [ROW_W-1:0]  clear_ff, clear_in;
   logic              e_valid_ff, e_valid_in;
   logic              m_valid_ff, m_valid_in;
   logic              halted_ff, halted_in;
   logic [31:0]       pc_ff, pc_in;
   logic              fwd_valid_ff, fwd_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [31:0]       instr_ff;
   logic [4:0]        fwd_idx_ff;
   logic [31:0]       fwd_val_ff;
   logic [4:0]        m_rd_ff;
   logic [2:0]        m_f3_ff;
   logic [1:0]        m_lo_ff;
   logic [31:0]       m_npc_ff;
   logic [31:0]       rsp_npc_ff;
   logic              rsp_wr_ff;
   logic [4:0]        rsp_idx_ff;
   logic [31:0]       rsp_val_ff;
   logic [1:0]        rsp_st_ff;
   logic [REG_COUNT-1:0] rf_valid_ff;

   // handshake and stage movement
   logic accept, out_free, m_fire, e_fire, e_load_go, e_done;

   // register file ports
   logic             rf_wr_en;
   logic [4:0]       rf_wr_idx;
   logic [31:0]      rf_wr_val;
   logic [31:0]      rf_a_raw, rf_b_raw;

   // execute stage decode
   logic [6:0]  op, f7;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [31:0] imm_i, imm_s, imm_b, imm_j;
   logic [31:0] opa, opb, alu_b, alu_y;
   logic        alu_alt;
   logic        legal, use_rd, use_rs1, use_rs2, take;
   logic        e_is_load, e_is_store, e_wr;
   logic [31:0] e_val, e_npc, mem_addr;
   status_type  e_status;
   logic [2:0]  st_size;

   // data memory bank ports
   logic [3:0]       bk_wr_en;
   logic [ROW_W-1:0] bk_wr_addr [4];
   logic [7:0]       bk_wr_data [4];
   logic [ROW_W-1:0] bk_rd_addr [4];
   logic [7:0]       bk_rd_data [4];
   logic [31:0]      m_word, m_val;
   logic             m_wr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign m_fire    = m_valid_ff && out_free;
   assign e_fire    = e_valid_ff && (e_is_load ? !m_valid_ff : (!m_valid_ff && out_free));
   assign e_load_go = e_fire && e_is_load;
   assign e_done    = e_fire && !e_is_load;
   assign req_stall = clearing_ff || (e_valid_ff && !e_done) || (m_valid_ff && !m_fire);
   assign accept    = req_valid && !req_stall;

   // register file: two copies for two read ports
   rv32ie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
      .clock  (clock),
      .wr_en  (rf_wr_en),
      .wr_addr(rf_wr_idx[RF_AW-1:0]),
      .wr_data(rf_wr_val),
      .rd_en  (accept),
      .rd_addr(req_instr_word[15 +: RF_AW]),
      .rd_data(rf_a_raw)
   );

   rv32ie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
      .clock  (clock),
      .wr_en  (rf_wr_en),
      .wr_addr(rf_wr_idx[RF_AW-1:0]),
      .wr_data(rf_wr_val),
      .rd_en  (accept),
      .rd_addr(req_instr_word[20 +: RF_AW]),
      .rd_data(rf_b_raw)
   );

   // decode fields and immediates
   always_comb begin
      op    = instr_ff[6:0] & OP_MASK;
      rd    = instr_ff[11:7];
      f3    = instr_ff[14:12];
      rs1   = instr_ff[19:15];
      rs2   = instr_ff[24:20];
      f7    = instr_ff[31:25];
      imm_i = {{20{instr_ff[31]}}, instr_ff[31:20]};
      imm_s = {{20{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
      imm_b = {{19{instr_ff[31]}}, instr_ff[31], instr_ff[7], instr_ff[30:25],
               instr_ff[11:8], 1'b0};
      imm_j = {{11{instr_ff[31]}}, instr_ff[31], instr_ff[19:12], instr_ff[20],
               instr_ff[30:21], 1'b0};
   end

   // pick operands: same-edge write forward, then unwritten or x0 as zero
   always_comb begin
      if (rs1 == 5'd0) opa = 32'd0;
      else if (fwd_valid_ff && fwd_idx_ff == rs1) opa = fwd_val_ff;
      else if (rf_valid_ff[rs1[RF_AW-1:0]]) opa = rf_a_raw;
      else opa = 32'd0;
      if (rs2 == 5'd0) opb = 32'd0;
      else if (fwd_valid_ff && fwd_idx_ff == rs2) opb = fwd_val_ff;
      else if (rf_valid_ff[rs2[RF_AW-1:0]]) opb = rf_b_raw;
      else opb = 32'd0;
   end

   // ALU
   always_comb begin
      if (op == OP_IMM) begin
         alu_b   = (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, rs2} : imm_i;
         alu_alt = (f3 == F3_SR) && (f7 == F7_ALT);
      end else begin
         alu_b   = opb;
         alu_alt = (f7 == F7_ALT);
      end
      case (f3)
         F3_ADD:  alu_y = alu_alt ? opa - alu_b : opa + alu_b;
         F3_SLL:  alu_y = opa << alu_b[4:0];
         F3_SLT:  alu_y = {31'd0, $signed(opa) < $signed(alu_b)};
         F3_SLTU: alu_y = {31'd0, opa < alu_b};
         F3_XOR:  alu_y = opa ^ alu_b;
         F3_SR:   alu_y = alu_alt ? 32'($signed(opa) >>> alu_b[4:0]) : opa >> alu_b[4:0];
         F3_OR:   alu_y = opa | alu_b;
         default: alu_y = opa & alu_b;
      endcase
   end

   // branch condition
   always_comb begin
      case (f3)
         F3_BEQ:  take = opa == opb;
         F3_BNE:  take = opa != opb;
         F3_BLT:  take = $signed(opa) < $signed(opb);
         F3_BGE:  take = $signed(opa) >= $signed(opb);
         F3_BLTU: take = opa < opb;
         default: take = opa >= opb;
      endcase
   end

   // legality and execute result
   always_comb begin
      legal   = 1'b1;
      use_rd  = 1'b0;
      use_rs1 = 1'b0;
      use_rs2 = 1'b0;
      case (op)
         OP_REG: begin
            use_rd = 1'b1; use_rs1 = 1'b1; use_rs2 = 1'b1;
            legal = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR));
         end
         OP_IMM: begin
            use_rd = 1'b1; use_rs1 = 1'b1;
            if (f3 == F3_SLL) legal = (f7 == F7_BASE);
            if (f3 == F3_SR) legal = (f7 == F7_BASE) || (f7 == F7_ALT);
         end
         OP_LOAD: begin
            use_rd = 1'b1; use_rs1 = 1'b1;
            legal = (f3 == F3_B) || (f3 == F3_H) || (f3 == F3_W) || (f3 == F3_BU)
                    || (f3 == F3_HU);
         end
         OP_STORE: begin
            use_rs1 = 1'b1; use_rs2 = 1'b1;
            legal = (f3 == F3_B) || (f3 == F3_H) || (f3 == F3_W);
         end
         OP_BRANCH: begin
            use_rs1 = 1'b1; use_rs2 = 1'b1;
            legal = (f3 != 3'd2) && (f3 != 3'd3);
         end
         OP_JALR: begin
            use_rd = 1'b1; use_rs1 = 1'b1;
            legal = (f3 == 3'd0);
         end
         OP_LUI, OP_AUIPC, OP_JAL: use_rd = 1'b1;
         default: legal = 1'b0;
      endcase
      if ((use_rd && 32'(rd) >= REG_COUNT) || (use_rs1 && 32'(rs1) >= REG_COUNT) ||
          (use_rs2 && 32'(rs2) >= REG_COUNT)) begin
         legal = 1'b0;
      end

      e_val      = 32'd0;
      e_wr       = 1'b0;
      e_npc      = pc_ff + 32'd4;
      e_is_load  = 1'b0;
      e_is_store = 1'b0;
      mem_addr   = opa + ((op == OP_STORE) ? imm_s : imm_i);
      if (halted_ff || op == OP_SYSTEM) begin
         e_status = ST_HALT;
      end else if (!legal) begin
         e_status = ST_ILLEGAL;
      end else begin
         e_status = ST_OK;
         case (op)
            OP_REG, OP_IMM: begin
               e_val = alu_y; e_wr = 1'b1;
            end
            OP_LOAD:   e_is_load = 1'b1;
            OP_STORE:  e_is_store = 1'b1;
            OP_BRANCH: if (take) e_npc = pc_ff + imm_b;
            OP_LUI: begin
               e_val = instr_ff & UPPER_MASK; e_wr = 1'b1;
            end
            OP_AUIPC: begin
               e_val = pc_ff + (instr_ff & UPPER_MASK); e_wr = 1'b1;
            end
            OP_JAL: begin
               e_val = pc_ff + 32'd4; e_npc = pc_ff + imm_j; e_wr = 1'b1;
            end
            default: begin
               e_val = pc_ff + 32'd4; e_npc = (opa + imm_i) & ~32'd1; e_wr = 1'b1;
            end
         endcase
      end
      if (rd == 5'd0) e_wr = 1'b0;
      if (e_status != ST_OK) e_npc = pc_ff;
   end

   // data memory banks: byte k of an access goes to bank (addr + k) mod 4
   always_comb begin
      case (f3)
         F3_B:    st_size = 3'd1;
         F3_H:    st_size = 3'd2;
         default: st_size = 3'd4;
      endcase
      for (int j = 0; j < 4; j++) begin
         logic [1:0] k;
         k = 2'(j) - mem_addr[1:0];
         bk_rd_addr[j] = mem_addr[ADDR_W-1:2] + ROW_W'(2'(j) < mem_addr[1:0]);
         if (clearing_ff) begin
            bk_wr_en[j]   = 1'b1;
            bk_wr_addr[j] = clear_ff;
            bk_wr_data[j] = 8'd0;
         end else begin
            bk_wr_en[j]   = e_fire && e_is_store && ({1'b0, k} < st_size);
            bk_wr_addr[j] = bk_rd_addr[j];
            bk_wr_data[j] = opb[8*k +: 8];
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      rv32ie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
         .clock  (clock),
         .wr_en  (bk_wr_en[g]),
         .wr_addr(bk_wr_addr[g]),
         .wr_data(bk_wr_data[g]),
         .rd_en  (e_load_go),
         .rd_addr(bk_rd_addr[g]),
         .rd_data(bk_rd_data[g])
      );
   end

   // gather load bytes and extend
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         m_word[8*k +: 8] = bk_rd_data[2'(k) + m_lo_ff];
      end
      case (m_f3_ff)
         F3_B:    m_val = {{24{m_word[7]}}, m_word[7:0]};
         F3_H:    m_val = {{16{m_word[15]}}, m_word[15:0]};
         F3_BU:   m_val = {24'd0, m_word[7:0]};
         F3_HU:   m_val = {16'd0, m_word[15:0]};
         default: m_val = m_word;
      endcase
      m_wr = (m_rd_ff != 5'd0);
   end

   // register file write from load or execute
   always_comb begin
      if (m_fire) begin
         rf_wr_en = m_wr; rf_wr_idx = m_rd_ff; rf_wr_val = m_val;
      end else begin
         rf_wr_en = e_done && e_wr; rf_wr_idx = rd; rf_wr_val = e_val;
      end
   end

   // next control state
   always_comb begin
      clearing_in  = clearing_ff;
      clear_in     = clear_ff;
      if (clearing_ff) begin
         clear_in = clear_ff + ROW_W'(1);
         if (32'(clear_ff) == ROWS - 1) clearing_in = 1'b0;
      end
      e_valid_in   = accept ? 1'b1 : (e_fire ? 1'b0 : e_valid_ff);
      m_valid_in   = e_load_go ? 1'b1 : (m_fire ? 1'b0 : m_valid_ff);
      halted_in    = halted_ff || (e_fire && e_status == ST_HALT);
      pc_in        = (e_fire && e_status == ST_OK) ? e_npc : pc_ff;
      fwd_valid_in = rf_wr_en ? 1'b1 : (accept ? 1'b0 : fwd_valid_ff);
      rsp_valid_in = e_done || m_fire || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_ff     <= '0;
         e_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         halted_ff    <= 1'b0;
         pc_ff        <= 32'd0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_ff     <= clear_in;
         e_valid_ff   <= e_valid_in;
         m_valid_ff   <= m_valid_in;
         halted_ff    <= halted_in;
         pc_ff        <= pc_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_wr_en) rf_valid_ff[rf_wr_idx[RF_AW-1:0]] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) instr_ff <= req_instr_word;
      if (rf_wr_en) begin
         fwd_idx_ff <= rf_wr_idx;
         fwd_val_ff <= rf_wr_val;
      end
      if (e_load_go) begin
         m_rd_ff  <= rd;
         m_f3_ff  <= f3;
         m_lo_ff  <= mem_addr[1:0];
         m_npc_ff <= e_npc;
      end
      if (m_fire) begin
         rsp_npc_ff <= m_npc_ff;
         rsp_wr_ff  <= m_wr;
         rsp_idx_ff <= m_wr ? m_rd_ff : 5'd0;
         rsp_val_ff <= m_wr ? m_val : 32'd0;
         rsp_st_ff  <= ST_OK;
      end else if (e_done) begin
         rsp_npc_ff <= e_npc;
         rsp_wr_ff  <= e_wr;
         rsp_idx_ff <= e_wr ? rd : 5'd0;
         rsp_val_ff <= e_wr ? e_val : 32'd0;
         rsp_st_ff  <= e_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_npc_ff;
   assign rsp_reg_written = rsp_wr_ff;
   assign rsp_dest_index  = rsp_idx_ff;
   assign rsp_dest_value  = rsp_val_ff;
   assign rsp_exec_status = rsp_st_ff;

`ifndef SYNTHESIS
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !accept) else $error("request accepted during memory clear");
   a_m_blocks_e: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff |-> !e_done) else $error("execute result overtook a pending load");
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_wr_en |-> rf_wr_idx != 5'd0) else $error("write to x0");
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(m_fire && e_done)) else $error("two results in one cycle");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff) else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

### design/rv32ie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rv32ie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
